// File: design/lsct_pkg.sv
// shared types and constants for the load/store cache hit tracker
package lsct_pkg;

  localparam logic [31:0] ADDR_BASE = 32'h1000_0000;

  localparam int TAG_W   = 22;
  localparam int TAG_LSB = 10;

  // set index sits right above the line offset: 32-byte lines direct, 64-byte lines 4-way
  localparam int DIRECT_IDX_LSB = 5;
  localparam int ASSOC_IDX_LSB  = 6;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_STORE   = 1'b1;
  localparam logic MODE_DIRECT = 1'b0;
  localparam logic MODE_ASSOC  = 1'b1;

  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    logic load;
    logic read;
    logic compare;
    logic commit;
  } lsct_cmd_t;

endpackage

// File: design/lsct_ram.sv
// generic single-write, single-read ram with registered read data
module lsct_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: design/lsct_ctrl.sv
// controller state machine: sequences tag read, compare and commit
module lsct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output lsct_pkg::lsct_cmd_t cmd
);
  import lsct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_COMMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not present a result");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result appeared without a commit");

  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.read || cmd.compare || cmd.commit))
    else $error("datapath command issued while idle");

endmodule

// File: design/lsct_dp.sv
// datapath: set index, tag stores, lru ages, hit/miss counters, result register
module lsct_dp #(
  parameter int DIRECT_SETS = 32,
  parameter int ASSOC_SETS  = 16,
  parameter int ASSOC_WAYS  = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lsct_pkg::lsct_cmd_t               cmd,
  input  logic                              req_type,
  input  logic [31:0]                       access_address,
  input  logic                              cfg_we,
  input  logic                              cfg_mode,
  output logic [lsct_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import lsct_pkg::*;

  localparam int DW    = $clog2(DIRECT_SETS);
  localparam int AIW   = $clog2(ASSOC_SETS);
  localparam int WW    = $clog2(ASSOC_WAYS);
  localparam int ROW_W = ASSOC_WAYS * TAG_W;

  logic                mode_r;
  logic                store_r;
  tag_t                tag_r;
  logic [DW-1:0]       dset_r;
  logic [AIW-1:0]      aset_r;
  logic [DIRECT_SETS-1:0]                             dvalid_r;
  logic [ASSOC_SETS-1:0][ASSOC_WAYS-1:0]              avalid_r;
  logic [ASSOC_SETS-1:0][ASSOC_WAYS-1:0][WW-1:0]      age_r;
  logic                hit_r;
  logic [WW-1:0]       way_r;
  logic                out_hit_r;
  logic [WW-1:0]       out_way_r;
  logic [31:0]         hit_cnt_r, miss_cnt_r;

  logic [31:0]         offset;
  logic [DW-1:0]       dset;
  logic [AIW-1:0]      aset;
  tag_t                dtag_q;
  logic [ROW_W-1:0]    arow_q, arow_wr;
  logic                dwe, awe;
  logic                dhit, found, got_inv, cmp_hit;
  logic [WW-1:0]       hway, iway, lway, sel_way, limit;
  logic [WW-1:0]       best;
  logic [ASSOC_WAYS-1:0][WW-1:0] age_set_nxt;

  assign offset = access_address - ADDR_BASE;
  assign dset   = dset_r;
  assign aset   = aset_r;

  lsct_ram #(.WIDTH(TAG_W), .DEPTH(DIRECT_SETS)) u_dtag (
    .clk   (clk),
    .we    (dwe),
    .waddr (dset),
    .wdata (tag_r),
    .re    (cmd.read),
    .raddr (dset),
    .rdata (dtag_q)
  );

  lsct_ram #(.WIDTH(ROW_W), .DEPTH(ASSOC_SETS)) u_atag (
    .clk   (clk),
    .we    (awe),
    .waddr (aset),
    .wdata (arow_wr),
    .re    (cmd.read),
    .raddr (aset),
    .rdata (arow_q)
  );

  // tag compare and victim choice
  always_comb begin
    dhit    = dvalid_r[dset] && (dtag_q == tag_r);
    found   = 1'b0;
    got_inv = 1'b0;
    hway    = '0;
    iway    = '0;
    for (int w = ASSOC_WAYS - 1; w >= 0; w--) begin
      if (avalid_r[aset][w] && (arow_q[w*TAG_W +: TAG_W] == tag_r)) begin
        found = 1'b1;
        hway  = WW'(w);
      end
      if (!avalid_r[aset][w]) begin
        got_inv = 1'b1;
        iway    = WW'(w);
      end
    end
    // oldest way, lowest index on a tie
    best = age_r[aset][0];
    lway = '0;
    for (int w = 1; w < ASSOC_WAYS; w++) begin
      if (age_r[aset][w] > best) begin
        best = age_r[aset][w];
        lway = WW'(w);
      end
    end
    sel_way = found ? hway : (got_inv ? iway : lway);
    cmp_hit = (mode_r == MODE_ASSOC) ? found : dhit;
  end

  assign dwe = cmd.commit && (mode_r == MODE_DIRECT) && !hit_r && (store_r == REQ_LOAD);
  assign awe = cmd.commit && (mode_r == MODE_ASSOC);

  always_comb begin
    arow_wr = arow_q;
    arow_wr[way_r*TAG_W +: TAG_W] = tag_r;
  end

  // true-lru age update of the accessed set
  always_comb begin
    limit = hit_r ? age_r[aset][way_r] : WW'(ASSOC_WAYS - 1);
    for (int w = 0; w < ASSOC_WAYS; w++) begin
      if (WW'(w) == way_r) begin
        age_set_nxt[w] = '0;
      end else if (avalid_r[aset][w] && (age_r[aset][w] < limit)) begin
        age_set_nxt[w] = age_r[aset][w] + 1'b1;
      end else begin
        age_set_nxt[w] = age_r[aset][w];
      end
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_DIRECT;
      dvalid_r   <= '0;
      avalid_r   <= '0;
      age_r      <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_mode;
      end
      if (dwe) begin
        dvalid_r[dset] <= 1'b1;
      end
      if (awe) begin
        age_r[aset]           <= age_set_nxt;
        avalid_r[aset][way_r] <= 1'b1;
      end
      if (cmd.commit) begin
        if (hit_r) begin
          if (hit_cnt_r != '1) begin
            hit_cnt_r <= hit_cnt_r + 1'b1;
          end
        end else begin
          if (miss_cnt_r != '1) begin
            miss_cnt_r <= miss_cnt_r + 1'b1;
          end
        end
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_r <= req_type;
      tag_r   <= offset[31:TAG_LSB];
      dset_r  <= offset[DIRECT_IDX_LSB +: DW];
      aset_r  <= offset[ASSOC_IDX_LSB +: AIW];
    end
    if (cmd.compare) begin
      hit_r <= cmp_hit;
      way_r <= (mode_r == MODE_ASSOC) ? sel_way : '0;
    end
    if (cmd.commit) begin
      out_hit_r <= hit_r;
      out_way_r <= way_r;
    end
  end

  // counters only move at commit, so they stand for the waiting result
  assign out_tdata = {5'b0, miss_cnt_r, hit_cnt_r, 2'(out_way_r), out_hit_r};

  a_cnt_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.commit)) |-> ($stable(hit_cnt_r) && $stable(miss_cnt_r)))
    else $error("counter moved without a commit");

  a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !((hit_cnt_r != $past(hit_cnt_r)) && (miss_cnt_r != $past(miss_cnt_r))))
    else $error("hit and miss counters moved together");

endmodule

// File: design/load_store_cache_hit_tracker.sv
// path: an input transaction moves through tag ram read, compare and commit, and
// out_tvalid is registered from the commit. A new item is taken only after the last
// one has committed; a held result stalls only the commit step.
// reset: rst_n synchronous active low; clears all valid bits, lru ages, counters and
// cache_mode at once, so the block takes items on the first cycle after reset.
module load_store_cache_hit_tracker #(
  parameter int DIRECT_SETS = 32,
  parameter int ASSOC_SETS  = 16,
  parameter int ASSOC_WAYS  = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lsct_pkg::IN_DATA_W-1:0]      in_tdata,   // [31:0] access_address
  input  logic                                in_tuser,   // [0] req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lsct_pkg::OUT_DATA_W-1:0]     out_tdata,  // [0] was_hit, [2:1] way_used,
                                                          // [34:3] hit_total,
                                                          // [66:35] miss_total, rest zero
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data    // cache_mode
);
  import lsct_pkg::*;

  lsct_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lsct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lsct_dp #(
    .DIRECT_SETS (DIRECT_SETS),
    .ASSOC_SETS  (ASSOC_SETS),
    .ASSOC_WAYS  (ASSOC_WAYS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .req_type       (in_tuser),
    .access_address (in_tdata),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_mode       (cfg_data),
    .out_tdata      (out_tdata)
  );

endmodule
